// ----- rtl/rtd_pkg.sv -----
package rtd_pkg;

  localparam int unsigned SampleW = 12;
  localparam int unsigned RefW    = 24;
  localparam int unsigned NomW    = 20;
  localparam int unsigned TempW   = 17;
  localparam int unsigned StatW   = 2;

  // Status codes of a result item.
  localparam logic [StatW-1:0] StOk   = 2'd0;
  localparam logic [StatW-1:0] StVolt = 2'd1;
  localparam logic [StatW-1:0] StRes  = 2'd2;
  localparam logic [StatW-1:0] StTemp = 2'd3;

  // Configuration register indexes.
  localparam logic CfgRef = 1'b0;
  localparam logic CfgNom = 1'b1;

  // Callendar-Van Dusen constants, scaled to integers.
  localparam logic [63:0] DiscA2 = 64'd1527480889;
  localparam logic [31:0] Disc4B = 32'd231000000;
  localparam logic [31:0] CoefA  = 32'd39083;
  localparam logic [31:0] Den2B  = 32'd1155;

  // Reciprocal of 1155: for any dividend below 2^26,
  // floor(m / 1155) == (m * Den2BRecip) >> RecipShift.
  localparam logic [26:0] Den2BRecip = 27'd118994765;
  localparam int unsigned RecipShift = 37;

  // Averaged reading handed from the front part to the back part.
  typedef logic [SampleW-1:0] avg_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp_centi;
    logic [StatW-1:0]        status;
  } result_t;

endpackage

// ----- rtl/rtd_front.sv -----
module rtd_front #(
  parameter int unsigned SamplesPerReading = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [rtd_pkg::SampleW-1:0] sample_i,
  input  logic                        sample_ok_i,
  output logic                        avg_valid_o,
  input  logic                        avg_ready_i,
  output rtd_pkg::avg_t               avg_o
);

  localparam int unsigned CntW = (SamplesPerReading > 1) ? $clog2(SamplesPerReading) : 1;
  localparam int unsigned SumW = rtd_pkg::SampleW + $clog2(SamplesPerReading + 1);
  localparam int unsigned QDepth = 2;

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SumW-1:0] sum_q, sum_d, sum_new;
  rtd_pkg::avg_t   fifo_q [QDepth];
  logic [1:0]      fill_q, fill_d;
  logic            wr_ptr_q, rd_ptr_q;
  logic            push, pop, last;

  assign in_ready_o  = (fill_q != 2'(QDepth));
  assign avg_valid_o = (fill_q != 2'd0);
  assign avg_o       = fifo_q[rd_ptr_q];
  assign pop         = avg_valid_o && avg_ready_i;

  assign sum_new = sum_q + (sample_ok_i ? SumW'(sample_i) : '0);
  assign last    = (32'(cnt_q) == SamplesPerReading - 1);
  assign push    = in_valid_i && in_ready_o && last;

  always_comb begin
    cnt_d = cnt_q;
    sum_d = sum_q;
    if (in_valid_i && in_ready_o) begin
      if (last) begin
        cnt_d = '0;
        sum_d = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
        sum_d = sum_new;
      end
    end
    fill_d = fill_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      fill_q   <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      fill_q <= fill_d;
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= rtd_pkg::SampleW'(sum_new / SamplesPerReading);
  end

endmodule

// ----- rtl/rtd_divsqrt.sv -----
module rtd_divsqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        is_sqrt_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] res_o
);

  // Shared restoring unit: one quotient bit or one root bit a cycle.
  logic [63:0] rem_q, quo_q, den_q, val_q, bit_q;
  logic [6:0]  cnt_q;
  logic        busy_q, sqrt_q;
  logic [64:0] trial;
  logic [63:0] rem_sh;

  assign rem_sh = {rem_q[62:0], val_q[63]};
  assign trial  = {1'b0, rem_sh} - {1'b0, den_q};
  assign done_o = busy_q && (cnt_q == 7'd0);
  assign res_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= is_sqrt_i ? 7'd32 : 7'd64;
    end else if (busy_q) begin
      if (cnt_q == 7'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sqrt_q <= is_sqrt_i;
      rem_q  <= is_sqrt_i ? num_i : '0;
      val_q  <= num_i;
      den_q  <= den_i;
      quo_q  <= '0;
      bit_q  <= 64'h4000_0000_0000_0000;
    end else if (busy_q && cnt_q != 7'd0) begin
      if (sqrt_q) begin
        if (rem_q >= quo_q + bit_q) begin
          rem_q <= rem_q - (quo_q + bit_q);
          quo_q <= (quo_q >> 1) + bit_q;
        end else begin
          quo_q <= quo_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end else begin
        val_q <= {val_q[62:0], 1'b0};
        if (!trial[64]) begin
          rem_q <= trial[63:0];
          quo_q <= {quo_q[62:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[62:0], 1'b0};
        end
      end
    end
  end

endmodule

// ----- rtl/rtd_back.sv -----
module rtd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [rtd_pkg::RefW-1:0] ref_i,
  input  logic [rtd_pkg::NomW-1:0] nom_i,
  input  logic                     avg_valid_i,
  output logic                     avg_ready_o,
  input  rtd_pkg::avg_t            avg_i,
  output logic                     res_valid_o,
  input  logic                     res_ready_i,
  output rtd_pkg::result_t         res_o
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_CHK  = 10'b0000000010,
    S_RDIV = 10'b0000000100,
    S_XDIV = 10'b0000001000,
    S_MUL  = 10'b0000010000,
    S_SQRT = 10'b0000100000,
    S_NUM  = 10'b0001000000,
    S_TDIV = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_MULW = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  logic [11:0] avg_q;
  logic [43:0] num_q;        // ref * avg
  logic [11:0] den_q;        // 4095 - avg
  logic [34:0] xq_q;
  logic [63:0] work_q;
  logic [25:0] mag_q;        // |n| / 2^16
  logic        neg_q;

  logic        du_start, du_sqrt, du_done;
  logic [63:0] du_num, du_den, du_res;

  rtd_pkg::result_t res_q, out_q;
  logic             out_valid_q, out_valid_d, out_load;

  logic [18:0] av66;
  logic        volt_bad, res_bad, temp_bad;
  logic [63:0] mul_lo, mul_hi, mul_sum, disc_a, nmag;
  logic [63:0] lim_lo, lim_hi;
  logic [64:0] nval;
  logic signed [65:0] nsig;
  logic [52:0] tprod;
  logic [16:0] tmag;

  rtd_divsqrt u_divsqrt (
    .clk_i, .rst_ni,
    .start_i(du_start), .is_sqrt_i(du_sqrt),
    .num_i(du_num), .den_i(du_den),
    .done_o(du_done), .res_o(du_res)
  );

  assign avg_ready_o  = (state_q == S_IDLE);
  assign res_valid_o  = out_valid_q;
  assign res_o        = out_q;

  assign av66     = 19'(avg_q) * 19'd66;
  assign volt_bad = (av66 < 19'd4095) || (av66 > 19'd266175);
  assign res_bad  = (64'(num_q) < 64'(den_q) * 64'd10000) ||
                    (64'(num_q) > 64'(den_q) * 64'd500000) || (nom_i == '0);
  assign disc_a   = rtd_pkg::DiscA2 << 32;

  assign mul_lo  = 64'(rtd_pkg::Disc4B) * 64'(xq_q[31:0]);
  assign mul_hi  = 64'(rtd_pkg::Disc4B) * 64'(xq_q[34:32]);
  assign mul_sum = mul_lo + (mul_hi << 32);

  // n = 10000*(A*2^16 - s); sign kept in bit 64, magnitude in nmag.
  assign nsig = (66'(rtd_pkg::CoefA) <<< 16) - $signed({2'b0, work_q});
  assign nval = 65'(nsig * 66'sd10000);
  assign nmag = nval[64] ? (~nval[63:0] + 64'd1) : nval[63:0];

  assign lim_lo   = 64'(rtd_pkg::Den2B) * 64'd10000 * 64'd65536;
  assign lim_hi   = 64'(rtd_pkg::Den2B) * 64'd40000 * 64'd65536;
  assign temp_bad = nval[64] ? (nmag > lim_lo) : (nmag > lim_hi);

  // Final division by 1155*2^16: the 2^16 is a shift, the 1155 a reciprocal multiply.
  assign tprod = 53'(mag_q) * 53'(rtd_pkg::Den2BRecip);
  assign tmag  = {1'b0, tprod[rtd_pkg::RecipShift +: 16]};

  assign out_load = (state_q == S_OUT) && (!out_valid_q || res_ready_i);

  always_comb begin
    state_d  = state_q;
    du_start = 1'b0;
    du_sqrt  = 1'b0;
    du_num   = '0;
    du_den   = '0;
    unique case (state_q)
      S_IDLE: if (avg_valid_i) state_d = S_CHK;
      S_CHK:  state_d = (volt_bad || res_bad) ? S_OUT : S_RDIV;
      S_RDIV: if (du_done) state_d = S_XDIV;
      S_XDIV: begin
        if (du_done) state_d = (!neg_q && du_res >= (64'd8 << 32)) ? S_OUT : S_MUL;
      end
      S_MUL:  state_d = (!neg_q && mul_sum > disc_a) ? S_OUT : S_MULW;
      S_MULW: state_d = S_SQRT;
      S_SQRT: if (du_done) state_d = S_NUM;
      S_NUM:  state_d = temp_bad ? S_OUT : S_TDIV;
      S_TDIV: state_d = S_OUT;
      S_OUT:  if (!out_valid_q || res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
    if (state_q == S_CHK) begin
      du_start = 1'b1;
      du_num   = 64'(num_q);
      du_den   = 64'(den_q);
    end
    if (state_q == S_RDIV && du_done) begin
      du_start = 1'b1;
      du_num   = (du_res > 64'(nom_i) ? du_res - 64'(nom_i) : 64'(nom_i) - du_res) << 32;
      du_den   = 64'(nom_i);
    end
    if (state_q == S_MULW) begin
      du_start = 1'b1;
      du_sqrt  = 1'b1;
      du_num   = work_q;
    end
    out_valid_d = out_valid_q;
    if (res_valid_o && res_ready_i) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && avg_valid_i) begin
      avg_q <= avg_i;
      num_q <= 44'(ref_i) * 44'(avg_i);
      den_q <= 12'd4095 - avg_i;
    end
    if (state_q == S_CHK) begin
      res_q.temp_centi <= '0;
      if (volt_bad) res_q.status <= rtd_pkg::StVolt;
      else res_q.status <= rtd_pkg::StRes;
    end
    if (state_q == S_RDIV && du_done) neg_q <= du_res < 64'(nom_i);
    if (state_q == S_XDIV && du_done) begin
      xq_q         <= du_res[34:0];
      res_q.status <= rtd_pkg::StTemp;
    end
    if (state_q == S_MUL) work_q <= neg_q ? disc_a + mul_sum : disc_a - mul_sum;
    if (state_q == S_SQRT && du_done) work_q <= du_res;
    if (state_q == S_NUM) begin
      neg_q <= nval[64];
      mag_q <= nmag[41:16];
    end
    if (state_q == S_TDIV) begin
      res_q.status     <= rtd_pkg::StOk;
      res_q.temp_centi <= neg_q ? -tmag : tmag;
    end
    if (out_load) out_q <= res_q;
  end

endmodule

// ----- rtl/rtd_temperature_converter.sv -----
// RTD temperature converter for a PT100-style sensor in a resistor divider.
// Slave channel s_axis_*: one item per converter reading, tdata = {sample_ok, sample}.
// A failed read (sample_ok low) counts as zero. After SamplesPerReading items
// the truncated average is queued to the conversion engine, and one result
// item leaves on m_axis_*: tdata = {status, temp_centi}, temperature in
// hundredths of a degree, zero unless status is ok.
// Configuration channel cfg_*: index 0 is the reference resistor, index 1 the
// sensor resistance at zero degrees, both in milliohms; write only while idle.
// When the reading passes every check, the shared divide / square-root unit
// makes a 64-step resistance division, a 64-step ratio division and a 32-step
// square root, and the final division by a constant is a reciprocal multiply.
// Input items are accepted every cycle while the two-entry batch queue has
// room, so the next batch can be gathered while the engine converts one.
// Reset clears the accumulator, queue and sequencer and loads 100 ohm into
// both registers. A stalled master side holds its result; the engine and,
// once the queue fills, the slave side wait behind it.
module rtd_temperature_converter #(
  parameter int unsigned SamplesPerReading = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] sample, [12] sample_ok
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [16:0] temp_centi, [18:17] status
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  logic [rtd_pkg::RefW-1:0] ref_q;
  logic [rtd_pkg::NomW-1:0] nom_q;
  logic                     avg_valid, avg_ready;
  rtd_pkg::avg_t            avg;
  rtd_pkg::result_t         res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= 24'd100000;
      nom_q <= 20'd100000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rtd_pkg::CfgRef: ref_q <= cfg_data_i;
        rtd_pkg::CfgNom: nom_q <= cfg_data_i[rtd_pkg::NomW-1:0];
        default: ;
      endcase
    end
  end

  rtd_front #(.SamplesPerReading(SamplesPerReading)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sample_i   (s_axis_tdata[11:0]),
    .sample_ok_i(s_axis_tdata[12]),
    .avg_valid_o(avg_valid),
    .avg_ready_i(avg_ready),
    .avg_o      (avg)
  );

  rtd_back u_back (
    .clk_i, .rst_ni,
    .ref_i      (ref_q),
    .nom_i      (nom_q),
    .avg_valid_i(avg_valid),
    .avg_ready_o(avg_ready),
    .avg_i      (avg),
    .res_valid_o(m_axis_tvalid),
    .res_ready_i(m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tdata = {5'd0, res.status, res.temp_centi};

  // An error result always carries a zero temperature.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[18:17] != rtd_pkg::StOk |-> m_axis_tdata[16:0] == '0)
    else $error("error result with nonzero temperature");

  // A stalled result must not change.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

endmodule

// ----- dv/rtd_temperature_converter_tb.sv -----
module rtd_temperature_converter_tb;

  localparam int unsigned BatchLen     = 16;
  // Longest quiet stretch without any handshake before the run is abandoned.
  localparam int unsigned QuietLimit   = 20000;
  // Conversion latency of one batch, with margin, used before register writes.
  localparam int unsigned SettleCycles = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [11:0] sample, [12] sample_ok, [15:13] unused
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // [16:0] temp_centi, [18:17] status
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic        cfg_index_i;
  logic [23:0] cfg_data_i;

  rtd_temperature_converter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Local copy of the converter state: the two resistor registers and the
  // running batch accumulator.
  logic [63:0] ref_mohm;
  logic [63:0] nom_mohm;
  logic [31:0] batch_sum;
  int unsigned batch_fill;

  rtd_pkg::result_t expected_readings_q[$];
  int unsigned      mismatch_count;
  int unsigned      sender_idle_pct;
  int unsigned      receiver_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Integer square root, bit by bit, of the 64-bit discriminant.
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitpos;
    root   = '0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v    = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // Turns one averaged reading into the temperature result: divider voltage
  // check, sensor resistance, then the inverted Callendar-Van Dusen quadratic.
  function automatic rtd_pkg::result_t predict_reading(input logic [63:0] avg);
    logic [63:0]      num;
    logic [63:0]      den;
    logic [63:0]      res_mohm;
    logic [63:0]      diff;
    logic [63:0]      ratio_q32;
    logic [63:0]      disc;
    logic             below_nom;
    longint           numer;
    longint           den2b;
    rtd_pkg::result_t res;
    res.temp_centi = '0;
    res.status     = rtd_pkg::StOk;
    den2b          = longint'(rtd_pkg::Den2B) * 65536;
    if (avg * 66 < 64'd4095 || avg * 66 > 64'd266175) begin
      res.status = rtd_pkg::StVolt;
      return res;
    end
    num = ref_mohm * avg;
    den = 64'd4095 - avg;
    if (num < 64'd10000 * den || num > 64'd500000 * den || nom_mohm == 0) begin
      res.status = rtd_pkg::StRes;
      return res;
    end
    res_mohm  = num / den;
    below_nom = res_mohm < nom_mohm;
    diff      = below_nom ? nom_mohm - res_mohm : res_mohm - nom_mohm;
    ratio_q32 = (diff << 32) / nom_mohm;
    if (below_nom) begin
      disc = (rtd_pkg::DiscA2 << 32) + 64'(rtd_pkg::Disc4B) * ratio_q32;
    end else begin
      // A ratio too large for the square root leaves only the linear fallback,
      // which always lands far above the upper temperature limit.
      if (ratio_q32 >= (64'd8 << 32) ||
          64'(rtd_pkg::Disc4B) * ratio_q32 > (rtd_pkg::DiscA2 << 32)) begin
        res.status = rtd_pkg::StTemp;
        return res;
      end
      disc = (rtd_pkg::DiscA2 << 32) - 64'(rtd_pkg::Disc4B) * ratio_q32;
    end
    numer = (longint'(64'(rtd_pkg::CoefA) << 16) - longint'(int_sqrt(disc))) * 10000;
    if (numer < -10000 * den2b || numer > 40000 * den2b) begin
      res.status = rtd_pkg::StTemp;
      return res;
    end
    res.temp_centi = rtd_pkg::TempW'(numer / den2b);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Sends one input item, with random idle cycles in front of it, and updates
  // the local accumulator once the item is accepted.
  task automatic send_sample(input logic [11:0] sample, input logic sample_ok);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'($urandom), sample_ok, sample};
    do @(posedge clk_i); while (!s_axis_tready);
    if (sample_ok) batch_sum += sample;
    batch_fill++;
    if (batch_fill == BatchLen) begin
      expected_readings_q.push_back(predict_reading(64'(batch_sum / BatchLen)));
      batch_sum  = 0;
      batch_fill = 0;
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_readings_q.size() != 0) @(negedge clk_i);
  endtask

  // Registers change only when the converter has nothing in flight.
  task automatic write_register(input logic index, input logic [23:0] value);
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == rtd_pkg::CfgRef) ref_mohm = 64'(value);
    else nom_mohm = 64'(value[19:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_flat_batch(input logic [11:0] sample, input logic sample_ok);
    repeat (BatchLen) send_sample(sample, sample_ok);
  endtask

  // One batch: mostly samples clustered around a random level so that the
  // average lands anywhere in the range; otherwise pure noise.
  task automatic send_random_batch();
    int level;
    int spread;
    int s;
    level  = $urandom_range(4095);
    spread = $urandom_range(3) == 0 ? 4095 : $urandom_range(24);
    repeat (BatchLen) begin
      s = level + $urandom_range(2 * spread) - spread;
      if (s < 0) s = 0;
      if (s > 4095) s = 4095;
      send_sample(12'(s), $urandom_range(19) != 0);
    end
  endtask

  // Extremes of the sample field, failed reads, truncation of the average,
  // and every status with the reset register values.
  task automatic test_directed_batches();
    send_flat_batch(12'd4095, 1'b1);     // voltage too high
    send_flat_batch(12'd0, 1'b1);        // voltage too low
    send_flat_batch(12'hFFF, 1'b0);      // failed reads count as zero
    send_flat_batch(12'd2047, 1'b1);     // near zero degrees
    send_flat_batch(12'd63, 1'b1);       // lowest passing voltage
    send_flat_batch(12'd4032, 1'b1);     // highest passing voltage
    send_flat_batch(12'd1000, 1'b1);     // temperature too low
    send_flat_batch(12'd2700, 1'b1);     // hot but in range
    // Sum of 15 does not divide evenly: the average truncates.
    send_sample(12'd15, 1'b1);
    repeat (BatchLen - 1) send_sample(12'd2200, 1'b0);
    repeat (BatchLen - 1) send_sample(12'd2100, 1'b1);
    send_sample(12'd2115, 1'b1);
    wait_drained();
  endtask

  // Register extremes, including zero values, a tiny nominal resistance that
  // forces the linear fallback, and out-of-range register values.
  task automatic test_register_extremes();
    logic [23:0] refs[6];
    logic [19:0] noms[6];
    refs = '{24'd1000, 24'd10000000, 24'd0, 24'hFFFFFF, 24'd100000, 24'd430000};
    noms = '{20'd1000, 20'd1000000, 20'd100000, 20'd0, 20'hFFFFF, 20'd100000};
    for (int i = 0; i < 6; i++) begin
      write_register(rtd_pkg::CfgRef, refs[i]);
      write_register(rtd_pkg::CfgNom, 24'(noms[i]));
      send_flat_batch(12'd2047, 1'b1);
      send_flat_batch(12'd3000, 1'b1);
      repeat (4) send_random_batch();
    end
  endtask

  // Random traffic under each idling mode and a spread of register settings.
  task automatic test_random_traffic();
    int unsigned idle_modes[4][2];
    idle_modes = '{'{0, 0}, '{54, 0}, '{0, 54}, '{32, 32}};
    for (int m = 0; m < 4; m++) begin
      sender_idle_pct    = idle_modes[m][0];
      receiver_stall_pct = idle_modes[m][1];
      write_register(rtd_pkg::CfgRef, 24'($urandom_range(400000, 50000)));
      write_register(rtd_pkg::CfgNom, 24'($urandom_range(200000, 50000)));
      repeat (6) send_random_batch();
      // Hold the sender until every pending reading has come back.
      wait_drained();
      repeat (5) send_random_batch();
    end
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= $urandom_range(99) >= receiver_stall_pct;
  end

  // Each result item is compared against the oldest predicted reading.
  always @(posedge clk_i) begin
    rtd_pkg::result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_readings_q.size() == 0) begin
        report_mismatch("pending readings", 1, 0);
      end else begin
        want = expected_readings_q.pop_front();
        if (m_axis_tdata[16:0] != want.temp_centi)
          report_mismatch("temp_centi", $signed(m_axis_tdata[16:0]), want.temp_centi);
        if (m_axis_tdata[18:17] != want.status)
          report_mismatch("status", m_axis_tdata[18:17], want.status);
      end
    end
  end

  // Watchdog: ends the run if no handshake happens for too long.
  always @(posedge clk_i) begin
    int unsigned quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QuietLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    s_axis_tvalid      = 1'b0;
    s_axis_tdata       = '0;
    m_axis_tready      = 1'b0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = rtd_pkg::CfgRef;
    cfg_data_i         = '0;
    ref_mohm           = 64'd100000;
    nom_mohm           = 64'd100000;
    batch_sum          = 0;
    batch_fill         = 0;
    mismatch_count     = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_batches();
    test_register_extremes();
    test_random_traffic();

    wait_drained();
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatch_count == 0 && expected_readings_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rtd_pkg.sv
rtl/rtd_front.sv
rtl/rtd_divsqrt.sv
rtl/rtd_back.sv
rtl/rtd_temperature_converter.sv
dv/rtd_temperature_converter_tb.sv
